// ===== src/event_binary_frame_binner_core_macros.svh =====
// Assertion macros shared by the frame binner RTL.
// No dependencies; included by the modules that carry checks.
`ifndef EVENT_BINARY_FRAME_BINNER_CORE_MACROS_SVH
`define EVENT_BINARY_FRAME_BINNER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define EBFB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define EBFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== src/ebfb_pkg.sv =====
// Shared types and constants of the event frame binner.
// No dependencies; imported by every module of the block but ebfb_ram.
package ebfb_pkg;

  localparam int CHANNELS    = 2;
  localparam int WORD_BITS   = 64;
  localparam int WORD_SHIFT  = $clog2(WORD_BITS);
  localparam int TIME_BITS   = 48;
  localparam int SCALE_FRAC  = 12;
  localparam int QUEUE_DEPTH = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int COORD_W     = 15;
  localparam int PROD_W      = 26;

  localparam logic [15:0] SCALE_RESET   = 16'd4096;
  localparam logic [8:0]  PAD_X_RESET   = 9'd0;
  localparam logic [7:0]  PAD_Y_RESET   = 8'd0;
  localparam logic [31:0] WIN_LEN_RESET = 32'd10000;

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLOSE = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_SCALE   = 2'd0,
    CFG_PAD_X   = 2'd1,
    CFG_PAD_Y   = 2'd2,
    CFG_WIN_LEN = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_SET   = 2'd1,
    OP_RDCLR = 2'd2
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic                  ready;
    logic                  stored;
    logic [WORD_SHIFT-1:0] bit_pos;
  } q_ctl_t;

endpackage

// ===== src/ebfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ebfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2560
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ebfb_front.sv =====
// Front end: config registers, window tracking, pixel mapping and op classification.
// Depends on ebfb_pkg; feeds the op queue.
module ebfb_front import ebfb_pkg::*; #(
  parameter int FRAME_W = 320,
  parameter int FRAME_H = 256,
  parameter int AW      = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_acc,
  input  logic [1:0]            in_mode,
  input  logic [9:0]            in_sensor_x,
  input  logic [9:0]            in_sensor_y,
  input  logic                  in_polarity,
  input  logic                  in_event_valid,
  input  logic [TIME_BITS-1:0]  in_timestamp,
  input  logic [11:0]           in_word_index,
  output logic                  push,
  output logic [AW-1:0]         push_addr,
  output q_ctl_t                push_ctl,
  output logic [1:0]            inflight
);

  localparam int PLANE       = FRAME_H * FRAME_W;
  localparam int TOTAL       = CHANNELS * PLANE;
  localparam int FRAME_WORDS = (TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int BW          = $clog2(TOTAL);
  localparam int CW          = $clog2(FRAME_W);
  localparam int RW          = $clog2(FRAME_H);

  logic [15:0]          scale_r;
  logic [8:0]           pad_x_r;
  logic [7:0]           pad_y_r;
  logic [31:0]          win_len_r;

  logic                 win_open_r, win_open_nxt;
  logic [TIME_BITS-1:0] win_start_r, win_start_nxt;
  logic [TIME_BITS-1:0] win_end_r, win_end_nxt;

  logic                 v1_r, evt1_r, rd1_r, pol1_r, open1_r;
  logic [11:0]          widx1_r;
  logic [PROD_W-1:0]    px1_r, py1_r;
  logic [TIME_BITS-1:0] start1_r, end1_r;

  logic                 v2_r, evt2_r, rd2_r, pol2_r, ready2_r;
  logic [11:0]          widx2_r;
  logic [COORD_W-1:0]   mx2_r, my2_r;

  logic                 v3_r;
  logic [AW-1:0]        addr3_r;
  q_ctl_t               ctl3_r;

  logic                 in_frame;
  logic                 widx_ok;
  logic [BW-1:0]        bit_num;
  q_ctl_t               ctl3_nxt;
  logic [AW-1:0]        addr3_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r   <= SCALE_RESET;
      pad_x_r   <= PAD_X_RESET;
      pad_y_r   <= PAD_Y_RESET;
      win_len_r <= WIN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCALE:   scale_r   <= cfg_wdata[15:0];
        CFG_PAD_X:   pad_x_r   <= cfg_wdata[8:0];
        CFG_PAD_Y:   pad_y_r   <= cfg_wdata[7:0];
        CFG_WIN_LEN: win_len_r <= cfg_wdata[31:0];
      endcase
    end
  end

  always_comb begin
    win_open_nxt  = win_open_r;
    win_start_nxt = win_start_r;
    win_end_nxt   = win_end_r;
    if (in_acc) begin
      unique case (in_mode) inside
        MODE_EVENT: begin
          if (in_event_valid) begin
            if (!win_open_r) begin
              win_open_nxt  = 1'b1;
              win_start_nxt = in_timestamp;
              win_end_nxt   = in_timestamp;
            end else if (in_timestamp > win_end_r) begin
              win_end_nxt = in_timestamp;
            end
          end
        end
        MODE_CLOSE: begin
          win_open_nxt  = 1'b0;
          win_start_nxt = '0;
          win_end_nxt   = '0;
        end
        MODE_READ, MODE_NOP: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_open_r  <= 1'b0;
      win_start_r <= '0;
      win_end_r   <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
    end else begin
      win_open_r  <= win_open_nxt;
      win_start_r <= win_start_nxt;
      win_end_r   <= win_end_nxt;
      v1_r        <= in_acc;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
    end
  end

  // stage 1: coordinate products and window snapshot
  always_ff @(posedge clk) begin
    if (in_acc) begin
      evt1_r   <= (in_mode == MODE_EVENT) && in_event_valid;
      rd1_r    <= (in_mode == MODE_READ);
      pol1_r   <= in_polarity;
      widx1_r  <= in_word_index;
      px1_r    <= PROD_W'(in_sensor_x) * PROD_W'(scale_r);
      py1_r    <= PROD_W'(in_sensor_y) * PROD_W'(scale_r);
      open1_r  <= win_open_nxt;
      start1_r <= win_start_nxt;
      end1_r   <= win_end_nxt;
    end
  end

  // stage 2: letterbox offsets and window span check
  always_ff @(posedge clk) begin
    if (v1_r) begin
      evt2_r   <= evt1_r;
      rd2_r    <= rd1_r;
      pol2_r   <= pol1_r;
      widx2_r  <= widx1_r;
      mx2_r    <= COORD_W'(px1_r[PROD_W-1:SCALE_FRAC]) + COORD_W'(pad_x_r);
      my2_r    <= COORD_W'(py1_r[PROD_W-1:SCALE_FRAC]) + COORD_W'(pad_y_r);
      ready2_r <= open1_r && ((end1_r - start1_r) >= TIME_BITS'(win_len_r));
    end
  end

  // stage 3: frame bounds, bit address, op select
  always_comb begin
    in_frame = evt2_r && (mx2_r < COORD_W'(FRAME_W)) && (my2_r < COORD_W'(FRAME_H));
    widx_ok  = 32'(widx2_r) < 32'(FRAME_WORDS);
    bit_num  = (pol2_r ? BW'(PLANE) : BW'(0))
             + BW'(my2_r[RW-1:0]) * BW'(FRAME_W)
             + BW'(mx2_r[CW-1:0]);
    ctl3_nxt.ready   = ready2_r;
    ctl3_nxt.stored  = in_frame;
    ctl3_nxt.bit_pos = bit_num[WORD_SHIFT-1:0];
    if (in_frame) begin
      ctl3_nxt.op = OP_SET;
      addr3_nxt   = AW'(bit_num[BW-1:WORD_SHIFT]);
    end else if (rd2_r && widx_ok) begin
      ctl3_nxt.op = OP_RDCLR;
      addr3_nxt   = AW'(widx2_r);
    end else begin
      ctl3_nxt.op = OP_NONE;
      addr3_nxt   = AW'(widx2_r);
    end
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      addr3_r <= addr3_nxt;
      ctl3_r  <= ctl3_nxt;
    end
  end

  assign push      = v3_r;
  assign push_addr = addr3_r;
  assign push_ctl  = ctl3_r;
  assign inflight  = {1'b0, v1_r} + {1'b0, v2_r} + {1'b0, v3_r};

endmodule

// ===== src/ebfb_queue.sv =====
// Small FIFO decoupling the front end from the frame memory back end.
// Depends on ebfb_pkg for nothing but house style; standalone storage.
module ebfb_queue import ebfb_pkg::*; #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic [WIDTH-1:0]         push_data,
  input  logic                     pop,
  output logic                     head_valid,
  output logic [WIDTH-1:0]         head_data,
  output logic [$clog2(DEPTH):0]   count
);

  localparam int PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [PW:0]      count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      count_r <= count_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign count      = count_r;

endmodule

// ===== src/ebfb_back.sv =====
// Back end: frame memory clearing pass, read-modify-write of frame words, result register.
// Depends on ebfb_pkg, ebfb_ram and the assertion macro header.
`include "event_binary_frame_binner_core_macros.svh"

module ebfb_back import ebfb_pkg::*; #(
  parameter int AW    = 12,
  parameter int DEPTH = 2560
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  logic [AW-1:0]        q_addr,
  input  q_ctl_t               q_ctl,
  output logic                 q_pop,
  output logic                 clearing,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic                 out_window_ready,
  output logic                 out_event_stored,
  output logic [WORD_BITS-1:0] out_frame_word
);

  logic                 clr_r;
  logic [AW-1:0]        clr_cnt_r;

  logic                 b2_v_r;
  logic [AW-1:0]        b2_addr_r;
  q_ctl_t               b2_ctl_r;

  logic                 lw_v_r;
  logic [AW-1:0]        lw_addr_r;
  logic [WORD_BITS-1:0] lw_data_r;

  logic                 out_valid_r, out_ready_r, out_stored_r;
  logic [WORD_BITS-1:0] out_word_r;

  logic                 adv, commit, fwd_hit;
  logic [WORD_BITS-1:0] ram_rdata, cur, upd;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;

  assign adv    = !out_valid_r || !out_stall;
  assign q_pop  = !clr_r && q_valid && adv;
  assign commit = b2_v_r && adv;

  // last write forwarded over the read-old-data RAM
  assign fwd_hit = lw_v_r && (lw_addr_r == b2_addr_r);
  assign cur     = fwd_hit ? lw_data_r : ram_rdata;

  always_comb begin
    upd = cur;
    unique case (b2_ctl_r.op)
      OP_SET:   upd = cur | (WORD_BITS'(1) << b2_ctl_r.bit_pos);
      OP_RDCLR: upd = '0;
      default:  upd = cur;
    endcase
  end

  assign ram_we    = clr_r || (commit && (b2_ctl_r.op != OP_NONE));
  assign ram_waddr = clr_r ? clr_cnt_r : b2_addr_r;
  assign ram_wdata = clr_r ? '0 : upd;

  ebfb_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_frame_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= 1'b1;
      clr_cnt_r   <= '0;
      b2_v_r      <= 1'b0;
      lw_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (clr_r) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (adv) begin
        b2_v_r      <= q_pop;
        out_valid_r <= b2_v_r;
      end
      if (commit && (b2_ctl_r.op != OP_NONE)) begin
        lw_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b2_addr_r <= q_addr;
      b2_ctl_r  <= q_ctl;
    end
    if (commit && (b2_ctl_r.op != OP_NONE)) begin
      lw_addr_r <= b2_addr_r;
      lw_data_r <= upd;
    end
    if (commit) begin
      out_ready_r  <= b2_ctl_r.ready;
      out_stored_r <= b2_ctl_r.stored;
      out_word_r   <= (b2_ctl_r.op == OP_RDCLR) ? cur : '0;
    end
  end

  assign clearing         = clr_r;
  assign out_valid        = out_valid_r;
  assign out_window_ready = out_ready_r;
  assign out_event_stored = out_stored_r;
  assign out_frame_word   = out_word_r;

  `EBFB_ASSERT_NEXT(a_clear_once, clk, rst_n, !clr_r, !clr_r)
  `EBFB_ASSERT_IMPLY(a_clear_zero, clk, rst_n, clr_r, ram_we && (ram_wdata == '0) && !b2_v_r)
  `EBFB_ASSERT_IMPLY(a_stored_no_word, clk, rst_n, out_valid_r && out_stored_r, out_word_r == '0)

endmodule

// ===== src/event_binary_frame_binner_core.sv =====
// Event frame binner: bins camera events into a two-channel binary frame held in one
// RAM of 64-bit words (2*FRAME_H*FRAME_W bits, 2560 words at the default size). One
// transaction per clock is sustained while out_stall is low, and the front end keeps
// taking transactions while a result waits on out_stall until the op queue fills.
// Throughput is set by the frame RAM's one read and one write per cycle, used as a
// pipelined read-modify-write with forwarding of the last write. After reset, in_stall
// stays high for a clearing pass of one word per cycle over the whole frame RAM;
// configuration writes are taken meanwhile.
// Depends on ebfb_pkg, ebfb_front, ebfb_queue and ebfb_back.
module event_binary_frame_binner_core import ebfb_pkg::*; #(
  parameter int FRAME_W = 320,
  parameter int FRAME_H = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [9:0]            in_sensor_x,
  input  logic [9:0]            in_sensor_y,
  input  logic                  in_polarity,
  input  logic                  in_event_valid,
  input  logic [TIME_BITS-1:0]  in_timestamp,
  input  logic [11:0]           in_word_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_window_ready,
  output logic                  out_event_stored,
  output logic [WORD_BITS-1:0]  out_frame_word
);

  localparam int TOTAL       = CHANNELS * FRAME_H * FRAME_W;
  localparam int FRAME_WORDS = (TOTAL + WORD_BITS - 1) / WORD_BITS;
  localparam int AW          = $clog2(FRAME_WORDS);
  localparam int QW          = $bits(q_ctl_t) + AW;
  localparam int PW          = $clog2(QUEUE_DEPTH);

  logic          in_acc;
  logic          push, q_pop, q_valid, clearing;
  logic [1:0]    inflight;
  logic [AW-1:0] push_addr, q_addr;
  q_ctl_t        push_ctl, q_ctl;
  logic [QW-1:0] q_head;
  logic [PW:0]   q_count;
  logic [PW+1:0] credit_used;

  assign credit_used = (PW+2)'(q_count) + (PW+2)'(inflight);
  assign in_stall    = clearing || (credit_used >= (PW+2)'(QUEUE_DEPTH));
  assign in_acc      = in_valid && !in_stall;

  ebfb_front #(
    .FRAME_W (FRAME_W),
    .FRAME_H (FRAME_H),
    .AW      (AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_acc         (in_acc),
    .in_mode        (in_mode),
    .in_sensor_x    (in_sensor_x),
    .in_sensor_y    (in_sensor_y),
    .in_polarity    (in_polarity),
    .in_event_valid (in_event_valid),
    .in_timestamp   (in_timestamp),
    .in_word_index  (in_word_index),
    .push           (push),
    .push_addr      (push_addr),
    .push_ctl       (push_ctl),
    .inflight       (inflight)
  );

  ebfb_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_ctl, push_addr}),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_head),
    .count      (q_count)
  );

  assign {q_ctl, q_addr} = q_head;

  ebfb_back #(
    .AW    (AW),
    .DEPTH (FRAME_WORDS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_addr           (q_addr),
    .q_ctl            (q_ctl),
    .q_pop            (q_pop),
    .clearing         (clearing),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_window_ready (out_window_ready),
    .out_event_stored (out_event_stored),
    .out_frame_word   (out_frame_word)
  );

endmodule

// ===== tb/frame_binner_checker.sv =====
`timescale 1ns / 1ps
// Frame binner checker: watches the config port and both channels, predicts each result
// and compares it with what the block hands out. Depends on ebfb_pkg.
module frame_binner_checker import ebfb_pkg::*; #(
  parameter int FRAME_W = 320,
  parameter int FRAME_H = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            in_mode,
  input  logic [9:0]            in_sensor_x,
  input  logic [9:0]            in_sensor_y,
  input  logic                  in_polarity,
  input  logic                  in_event_valid,
  input  logic [TIME_BITS-1:0]  in_timestamp,
  input  logic [11:0]           in_word_index,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  out_window_ready,
  input  logic                  out_event_stored,
  input  logic [WORD_BITS-1:0]  out_frame_word,
  output int                    fail_count,
  output int                    pending
);

  localparam int FRAME_WORDS = (CHANNELS * FRAME_H * FRAME_W + WORD_BITS - 1) / WORD_BITS;
  localparam int MAX_REPORTS = 10;
  localparam int PEND_DEPTH  = 64;

  typedef struct packed {
    logic                 window_ready;
    logic                 event_stored;
    logic [WORD_BITS-1:0] frame_word;
  } bin_result_t;

  bin_result_t          pend_buf [PEND_DEPTH];
  int                   pend_wr;
  int                   pend_rd;
  logic [WORD_BITS-1:0] frame_mem [FRAME_WORDS];
  logic                 win_open;
  logic [TIME_BITS-1:0] win_start;
  logic [TIME_BITS-1:0] win_end;
  logic [15:0]          scale_q;
  logic [8:0]           pad_x_q;
  logic [7:0]           pad_y_q;
  logic [31:0]          win_len_q;

  task automatic report(input string what, input logic [WORD_BITS-1:0] want,
                        input logic [WORD_BITS-1:0] got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected %h, got %h", $time, what, want, got);
    end
  endtask

  task automatic bin_transaction(input mode_t mode, input logic [9:0] sx, input logic [9:0] sy,
                                 input logic pol, input logic ev,
                                 input logic [TIME_BITS-1:0] ts, input logic [11:0] widx);
    int unsigned mx, my, bitno;
    bin_result_t r;
    r = '0;
    case (mode)
      MODE_EVENT: if (ev) begin
        if (!win_open) begin
          win_open  = 1'b1;
          win_start = ts;
          win_end   = ts;
        end else if (ts > win_end) begin
          win_end = ts;
        end
        mx = ((32'(sx) * 32'(scale_q)) >> SCALE_FRAC) + 32'(pad_x_q);
        my = ((32'(sy) * 32'(scale_q)) >> SCALE_FRAC) + 32'(pad_y_q);
        if (mx < FRAME_W && my < FRAME_H) begin
          bitno = (pol ? FRAME_H * FRAME_W : 0) + my * FRAME_W + mx;
          frame_mem[bitno / WORD_BITS][bitno % WORD_BITS] = 1'b1;
          r.event_stored = 1'b1;
        end
      end
      MODE_READ: if (32'(widx) < FRAME_WORDS) begin
        r.frame_word    = frame_mem[widx];
        frame_mem[widx] = '0;
      end
      MODE_CLOSE: begin
        win_open  = 1'b0;
        win_start = '0;
        win_end   = '0;
      end
      default: ;
    endcase
    r.window_ready = win_open && ((win_end - win_start) >= {16'b0, win_len_q});
    if (pend_wr - pend_rd >= PEND_DEPTH) begin
      report("prediction buffer overflow", '0, '0);
    end else begin
      pend_buf[pend_wr % PEND_DEPTH] = r;
      pend_wr++;
    end
  endtask

  always @(posedge clk) begin
    bin_result_t want;
    if (!rst_n) begin
      foreach (frame_mem[w]) frame_mem[w] = '0;
      pend_wr    = 0;
      pend_rd    = 0;
      win_open   = 1'b0;
      win_start  = '0;
      win_end    = '0;
      scale_q    = SCALE_RESET;
      pad_x_q    = PAD_X_RESET;
      pad_y_q    = PAD_Y_RESET;
      win_len_q  = WIN_LEN_RESET;
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SCALE:   scale_q   = cfg_wdata[15:0];
          CFG_PAD_X:   pad_x_q   = cfg_wdata[8:0];
          CFG_PAD_Y:   pad_y_q   = cfg_wdata[7:0];
          CFG_WIN_LEN: win_len_q = cfg_wdata[31:0];
          default: ;
        endcase
      end
      // older results leave before this cycle's transaction is predicted
      if (out_valid && !out_stall) begin
        if (pend_wr == pend_rd) begin
          report("result with no transaction pending", '0, out_frame_word);
        end else begin
          want = pend_buf[pend_rd % PEND_DEPTH];
          pend_rd++;
          if (out_window_ready !== want.window_ready)
            report("window_ready", 64'(want.window_ready), 64'(out_window_ready));
          if (out_event_stored !== want.event_stored)
            report("event_stored", 64'(want.event_stored), 64'(out_event_stored));
          if (out_frame_word !== want.frame_word)
            report("frame_word", want.frame_word, out_frame_word);
        end
      end
      if (in_valid && !in_stall) begin
        bin_transaction(mode_t'(in_mode), in_sensor_x, in_sensor_y, in_polarity,
                        in_event_valid, in_timestamp, in_word_index);
      end
    end
    pending = pend_wr - pend_rd;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Testbench top for event_binary_frame_binner_core: clock, reset, config phases and
// randomized event / read / close traffic; verdict from frame_binner_checker.
module testbench;
  import ebfb_pkg::*;

  localparam int FRAME_W     = 320;
  localparam int FRAME_H     = 256;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 300;
  localparam int DRAIN       = 24;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_FIXED   = 7;
  localparam int HOT_DEPTH   = 16;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            in_mode;
  logic [9:0]            in_sensor_x;
  logic [9:0]            in_sensor_y;
  logic                  in_polarity;
  logic                  in_event_valid;
  logic [TIME_BITS-1:0]  in_timestamp;
  logic [11:0]           in_word_index;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_window_ready;
  logic                  out_event_stored;
  logic [WORD_BITS-1:0]  out_frame_word;
  int                    fail_count;
  int                    pending;
  int                    cycles;

  logic                  long_hold;
  logic                  tx_idle_on;
  logic                  rx_idle_on;
  logic [TIME_BITS-1:0]  now_us;
  logic [15:0]           cur_scale;
  logic [8:0]            cur_pad_x;
  logic [7:0]            cur_pad_y;
  int                    hot_buf [HOT_DEPTH];
  int                    hot_wr;
  int                    hot_cnt;

  logic [15:0] ph_scale [NUM_FIXED] = '{16'd4096, 16'd65535, 16'd0, 16'd2048, 16'd8192,
                                        16'd4095, 16'd4096};
  logic [8:0]  ph_pad_x [NUM_FIXED] = '{9'd0, 9'd319, 9'd0, 9'd40, 9'd10, 9'd319, 9'd0};
  logic [7:0]  ph_pad_y [NUM_FIXED] = '{8'd0, 8'd255, 8'd0, 8'd30, 8'd5, 8'd0, 8'd0};
  logic [31:0] ph_len   [NUM_FIXED] = '{32'd50, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd200,
                                        32'd1000, 32'd10000};

  event_binary_frame_binner_core #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_top (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_mode, .in_sensor_x, .in_sensor_y, .in_polarity,
    .in_event_valid, .in_timestamp, .in_word_index,
    .out_valid, .out_stall, .out_window_ready, .out_event_stored, .out_frame_word
  );

  frame_binner_checker #(.FRAME_W(FRAME_W), .FRAME_H(FRAME_H)) u_binner_check (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_wdata,
    .in_valid, .in_stall, .in_mode, .in_sensor_x, .in_sensor_y, .in_polarity,
    .in_event_valid, .in_timestamp, .in_word_index,
    .out_valid, .out_stall, .out_window_ready, .out_event_stored, .out_frame_word,
    .fail_count, .pending
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side: random stall per transaction, occasional long hold-off
  initial begin
    int gap;
    int taken;
    out_stall  = 1'b0;
    rx_idle_on = 1'b1;
    taken      = 0;
    forever begin
      @(negedge clk);
      if (taken % 64 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        long_hold = 1'b0;
      end
      gap = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      taken++;
    end
  end

  function automatic int mapped_word(logic [9:0] sx, logic [9:0] sy, logic pol);
    int unsigned mx, my;
    mx = ((32'(sx) * 32'(cur_scale)) >> SCALE_FRAC) + 32'(cur_pad_x);
    my = ((32'(sy) * 32'(cur_scale)) >> SCALE_FRAC) + 32'(cur_pad_y);
    if (mx >= FRAME_W || my >= FRAME_H) return -1;
    return int'(((pol ? FRAME_H * FRAME_W : 0) + my * FRAME_W + mx) / WORD_BITS);
  endfunction

  function automatic logic [TIME_BITS-1:0] rand_ts();
    logic [TIME_BITS-1:0] t;
    t[47:32] = 16'($urandom);
    t[31:0]  = $urandom;
    return t;
  endfunction

  function automatic logic [TIME_BITS-1:0] next_ts();
    logic [TIME_BITS-1:0] t;
    case ($urandom_range(0, 9))
      0: t = rand_ts();
      1: t = now_us - 48'($urandom_range(0, 500));
      2: begin
        now_us = now_us + 48'($urandom);
        t = now_us;
      end
      default: begin
        now_us = now_us + 48'($urandom_range(0, 64));
        t = now_us;
      end
    endcase
    return t;
  endfunction

  task automatic offer(input mode_t mode, input logic [9:0] sx, input logic [9:0] sy,
                       input logic pol, input logic ev, input logic [TIME_BITS-1:0] ts,
                       input logic [11:0] widx);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_sensor_x    <= sx;
    in_sensor_y    <= sy;
    in_polarity    <= pol;
    in_event_valid <= ev;
    in_timestamp   <= ts;
    in_word_index  <= widx;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic event_item(input logic [9:0] sx, input logic [9:0] sy, input logic pol,
                            input logic ev, input logic [TIME_BITS-1:0] ts);
    int w;
    w = mapped_word(sx, sy, pol);
    if (ev && w >= 0) begin
      hot_buf[hot_wr] = w;
      hot_wr = (hot_wr + 1) % HOT_DEPTH;
      if (hot_cnt < HOT_DEPTH) hot_cnt++;
    end
    offer(MODE_EVENT, sx, sy, pol, ev, ts, 12'($urandom));
  endtask

  task automatic read_item(input logic [11:0] widx);
    offer(MODE_READ, 10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom), rand_ts(),
          widx);
  endtask

  task automatic ctl_item(input mode_t mode);
    offer(mode, 10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom), rand_ts(),
          12'($urandom));
  endtask

  task automatic write_config(input logic [15:0] scale, input logic [8:0] px,
                              input logic [7:0] py, input logic [31:0] len);
    cfg_idx_t idx;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);
    for (int k = 0; k < 4; k++) begin
      idx = cfg_idx_t'(k);
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      case (idx)
        CFG_SCALE:   cfg_wdata <= {16'b0, scale};
        CFG_PAD_X:   cfg_wdata <= {23'b0, px};
        CFG_PAD_Y:   cfg_wdata <= {24'b0, py};
        CFG_WIN_LEN: cfg_wdata <= len;
        default:     cfg_wdata <= '0;
      endcase
      @(negedge clk);
    end
    cfg_we    <= 1'b0;
    cur_scale = scale;
    cur_pad_x = px;
    cur_pad_y = py;
    hot_wr    = 0;
    hot_cnt   = 0;
  endtask

  initial begin
    int pick;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_SCALE;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    in_mode        = MODE_EVENT;
    in_sensor_x    = '0;
    in_sensor_y    = '0;
    in_polarity    = 1'b0;
    in_event_valid = 1'b0;
    in_timestamp   = '0;
    in_word_index  = '0;
    long_hold      = 1'b0;
    tx_idle_on     = 1'b1;
    now_us         = '0;
    cur_scale      = SCALE_RESET;
    cur_pad_x      = PAD_X_RESET;
    cur_pad_y      = PAD_Y_RESET;
    hot_wr         = 0;
    hot_cnt        = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, reset configuration
    event_item(10'd0, 10'd0, 1'b0, 1'b1, 48'd100);
    event_item(10'd319, 10'd255, 1'b1, 1'b1, 48'd50);
    event_item(10'd320, 10'd0, 1'b0, 1'b1, 48'd200);
    event_item(10'd0, 10'd256, 1'b1, 1'b1, 48'd300);
    event_item(10'd1023, 10'd1023, 1'b1, 1'b1, 48'd10100);
    event_item(10'd5, 10'd5, 1'b0, 1'b0, 48'hFFFF_FFFF_FFFF);
    ctl_item(MODE_NOP);
    read_item(12'd0);
    read_item(12'd0);
    read_item(12'd2559);
    read_item(12'd2560);
    read_item(12'd4095);
    ctl_item(MODE_CLOSE);
    event_item(10'd5, 10'd7, 1'b1, 1'b1, 48'hFFFF_FFFF_FFFF);
    event_item(10'd63, 10'd0, 1'b0, 1'b1, 48'd0);
    read_item(12'd0);
    read_item(12'd1280 + 12'd11);
    ctl_item(MODE_CLOSE);
    event_item(10'd1, 10'd2, 1'b0, 1'b1, 48'd0);
    event_item(10'd1, 10'd2, 1'b1, 1'b1, 48'd9999);
    event_item(10'd2, 10'd2, 1'b1, 1'b1, 48'd10000);
    read_item(12'd10);
    read_item(12'd1290);

    for (int p = 0; p <= NUM_FIXED; p++) begin
      if (p < NUM_FIXED) write_config(ph_scale[p], ph_pad_x[p], ph_pad_y[p], ph_len[p]);
      else write_config(16'($urandom), 9'($urandom_range(0, 319)),
                        8'($urandom_range(0, 255)), $urandom_range(1, 5000));
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 50 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
        if ((p == 2 || p == 5) && i == 100) long_hold = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          if ($urandom_range(0, 4) != 0)
            event_item(10'($urandom_range(0, 63)), 10'($urandom_range(0, 15)),
                       1'($urandom), $urandom_range(0, 15) != 0, next_ts());
          else
            event_item(10'($urandom), 10'($urandom), 1'($urandom),
                       $urandom_range(0, 15) != 0, next_ts());
        end else if (pick < 80) begin
          if (hot_cnt > 0 && $urandom_range(0, 9) < 7)
            read_item(12'(hot_buf[$urandom_range(0, hot_cnt - 1)]));
          else
            read_item(12'($urandom));
        end else if (pick < 86) begin
          ctl_item(MODE_CLOSE);
        end else if (pick < 89) begin
          ctl_item(MODE_NOP);
        end else begin
          event_item(10'($urandom), 10'($urandom), 1'($urandom), 1'($urandom), rand_ts());
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/ebfb_pkg.sv
src/ebfb_ram.sv
src/ebfb_front.sv
src/ebfb_queue.sv
src/ebfb_back.sv
src/event_binary_frame_binner_core.sv
tb/frame_binner_checker.sv
tb/testbench.sv
